### hdl/sine_tone_note_generator_macros.svh
// Assertion macros shared by the sine tone note generator RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef SINE_TONE_NOTE_GENERATOR_MACROS_SVH
`define SINE_TONE_NOTE_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define STNG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define STNG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/stng_pkg.sv
// Shared types, constants and the quarter sine table for the tone generator.
// No dependencies; used by sine_tone_note_generator.
package stng_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;
    localparam int RATE_HZ         = 44100;
    localparam int DURATION_BITS   = 16;
    localparam int FREQ_BITS       = 23;
    localparam int FREQ_FRAC_BITS  = 8;
    localparam int SAMPLE_BITS     = 16;
    localparam int ROM_BITS        = 15;
    localparam int RUN_BITS        = 22;
    localparam int TOTAL_BITS      = 32;
    localparam int FULL_SCALE      = 32767;

    // step divider: {pad, freq, rounding bias} divided by RATE_HZ, 4 bits per cycle
    localparam int ROUND_BITS      = PHASE_BITS - FREQ_FRAC_BITS;
    localparam int DIV_BITS        = 1 + FREQ_BITS + ROUND_BITS;
    localparam int DIV_RADIX_BITS  = 4;
    localparam int DIV_STEPS       = DIV_BITS / DIV_RADIX_BITS;
    localparam int DIV_CNT_BITS    = $clog2(DIV_STEPS);
    localparam int REM_BITS        = $clog2(RATE_HZ);
    localparam logic [ROUND_BITS-1:0] ROUND_BIAS = ROUND_BITS'(RATE_HZ / 2);

    // run length: floor(dur * RATE_HZ / 1000) via reciprocal multiply
    localparam int RUN_PROD_BITS   = 32;
    localparam logic [63:0] MS_DIV_MAGIC = 64'h0000_0000_1062_4DD3;
    localparam int MS_DIV_SHIFT    = 38;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
    localparam int TAYLOR_TERMS = 13;
    localparam logic [9:0] TAYLOR_DIV [1:TAYLOR_TERMS] =
        '{10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210,
          10'd272, 10'd342, 10'd420, 10'd506, 10'd600, 10'd702};

    typedef enum logic [1:0] {
        OP_NOTE = 2'd0,
        OP_REST = 2'd1,
        OP_TICK = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_DIV,
        ST_LOAD
    } t_state;

    typedef logic [ROM_BITS-1:0] t_qsine_tab [TABLE_SIZE];

    // trunc(32767*sin(k*pi/2/TABLE_SIZE)) in Q62, Taylor series to x^27
    function automatic t_qsine_tab build_qsine();
        t_qsine_tab    tab;
        logic [127:0]  p;
        logic [63:0]   x;
        logic [63:0]   x2;
        logic [63:0]   term;
        logic [63:0]   sum;
        int            k;
        int            n;
        for (k = 0; k < TABLE_SIZE; k++) begin
            p = 128'(HALF_PI_Q62) * 128'(k);
            x = p[64+TABLE_ADDR_BITS-1:TABLE_ADDR_BITS];
            p = 128'(x) * 128'(x);
            x2 = p[125:62];
            term = x;
            sum = x;
            for (n = 1; n <= TAYLOR_TERMS; n++) begin
                p = 128'(term) * 128'(x2);
                term = p[125:62] / 64'(TAYLOR_DIV[n]);
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            p = 128'(sum) * 128'(FULL_SCALE);
            tab[k] = p[62+ROM_BITS-1:62];
        end
        return tab;
    endfunction

    localparam t_qsine_tab QSINE = build_qsine();

endpackage

### hdl/stng_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; holds the quarter sine table in the tone generator.
module stng_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/sine_tone_note_generator.sv
// Note-driven DDS sine tone generator: command decode, step divider, phase
// accumulator and table lookup. Uses stng_pkg, stng_ram and the macro header.
//
//   channel   direction  handshake          payload
//   command   in         i_valid / o_stall  i_opcode, i_freq_hz_q8, i_duration_ms
//   sample    out        o_valid / i_stall  o_sample, o_last_of_note, o_samples_so_far
//
// Sample ticks: one word per cycle sustained while the output is not stalled; a sample
// passes through the table RAM read, then the output register.
// Start note/rest: the word is taken, then input stalls through the 12 radix-16 steps
// of the phase step divider and the load state.
// Reset: the 1024-entry table RAM is filled one entry a cycle; input stalls until the fill is done.
// A stalled output register holds; the stall reaches the input only when the lookup stage is also full.
`include "sine_tone_note_generator_macros.svh"

module sine_tone_note_generator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [1:0]                             i_opcode,
    input  logic [stng_pkg::FREQ_BITS-1:0]         i_freq_hz_q8,
    input  logic [stng_pkg::DURATION_BITS-1:0]     i_duration_ms,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [stng_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                   o_last_of_note,
    output logic [stng_pkg::TOTAL_BITS-1:0]        o_samples_so_far
);

    stng_pkg::t_state r_state;
    stng_pkg::t_state n_state;

    logic                                      r_fill_active;
    logic                                      div_active;
    logic                                      load_active;
    logic                                      idle_active;

    logic [stng_pkg::TABLE_ADDR_BITS-1:0]      r_fill_cnt;
    logic [stng_pkg::DIV_CNT_BITS-1:0]         r_div_cnt;
    logic [stng_pkg::DIV_BITS-1:0]             r_div_num;
    logic [stng_pkg::REM_BITS-1:0]             r_div_rem;
    logic [stng_pkg::REM_BITS-1:0]             div_rem_nx;
    logic [stng_pkg::DIV_RADIX_BITS-1:0]       div_q;
    logic                                      r_cmd_rest;
    logic [stng_pkg::RUN_PROD_BITS-1:0]        r_run_prod;
    logic [63:0]                               run_full;
    logic [stng_pkg::RUN_BITS-1:0]             r_run_len;

    logic [stng_pkg::PHASE_BITS-1:0]           r_phase_acc;
    logic [stng_pkg::PHASE_BITS-1:0]           r_phase_step;
    logic [stng_pkg::RUN_BITS-1:0]             r_samples_left;
    logic                                      r_is_rest;
    logic [stng_pkg::TOTAL_BITS-1:0]           r_sample_total;

    logic                                      in_accept;
    logic                                      cmd_note;
    logic                                      cmd_rest;
    logic                                      tick_fire;

    logic [1:0]                                tab_quad;
    logic [stng_pkg::TABLE_ADDR_BITS-1:0]      tab_k;
    logic [stng_pkg::TABLE_ADDR_BITS-1:0]      tab_addr;
    logic [stng_pkg::ROM_BITS-1:0]             ram_q;

    logic                                      r_s1_valid;
    logic                                      r_s1_rest;
    logic                                      r_s1_full;
    logic                                      r_s1_neg;
    logic                                      r_s1_last;
    logic [stng_pkg::TOTAL_BITS-1:0]           r_s1_total;
    logic                                      s1_adv;

    logic [stng_pkg::ROM_BITS-1:0]             s1_mag;
    logic signed [stng_pkg::SAMPLE_BITS-1:0]   s1_pos;
    logic signed [stng_pkg::SAMPLE_BITS-1:0]   s1_sample;

    logic                                      r_out_valid;
    logic signed [stng_pkg::SAMPLE_BITS-1:0]   r_out_sample;
    logic                                      r_out_last;
    logic [stng_pkg::TOTAL_BITS-1:0]           r_out_total;

    // handshake
    assign s1_adv    = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = !idle_active || (r_s1_valid && !s1_adv);
    assign in_accept = i_valid && !o_stall;
    assign cmd_note  = in_accept && (i_opcode == stng_pkg::OP_NOTE);
    assign cmd_rest  = in_accept && (i_opcode == stng_pkg::OP_REST);
    assign tick_fire = in_accept && (i_opcode == stng_pkg::OP_TICK)
                       && (r_samples_left != '0);

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stng_pkg::ST_FILL: begin
                if (r_fill_cnt == '1) n_state = stng_pkg::ST_IDLE;
            end
            stng_pkg::ST_IDLE: begin
                if (cmd_note || cmd_rest) n_state = stng_pkg::ST_DIV;
            end
            stng_pkg::ST_DIV: begin
                if (r_div_cnt == stng_pkg::DIV_CNT_BITS'(stng_pkg::DIV_STEPS - 1)) begin
                    n_state = stng_pkg::ST_LOAD;
                end
            end
            stng_pkg::ST_LOAD: begin
                n_state = stng_pkg::ST_IDLE;
            end
            default: n_state = stng_pkg::ST_FILL;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        r_fill_active = 1'b0;
        div_active    = 1'b0;
        load_active   = 1'b0;
        idle_active   = 1'b0;
        unique case (r_state)
            stng_pkg::ST_FILL: r_fill_active = 1'b1;
            stng_pkg::ST_IDLE: idle_active   = 1'b1;
            stng_pkg::ST_DIV:  div_active    = 1'b1;
            stng_pkg::ST_LOAD: load_active   = 1'b1;
            default:           r_fill_active = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= stng_pkg::ST_FILL;
            r_fill_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_fill_active) begin
                r_fill_cnt <= r_fill_cnt + 1'b1;
            end
        end
    end

    // radix-16 restoring divide by RATE_HZ
    always_comb begin
        logic [stng_pkg::REM_BITS:0] t;
        logic [stng_pkg::REM_BITS-1:0] rem;
        rem   = r_div_rem;
        div_q = '0;
        for (int i = 0; i < stng_pkg::DIV_RADIX_BITS; i++) begin
            t = {rem, r_div_num[stng_pkg::DIV_BITS-1-i]};
            if (t >= (stng_pkg::REM_BITS+1)'(stng_pkg::RATE_HZ)) begin
                rem = stng_pkg::REM_BITS'(t - (stng_pkg::REM_BITS+1)'(stng_pkg::RATE_HZ));
                div_q[stng_pkg::DIV_RADIX_BITS-1-i] = 1'b1;
            end else begin
                rem = t[stng_pkg::REM_BITS-1:0];
            end
        end
        div_rem_nx = rem;
    end

    assign run_full = 64'(r_run_prod) * stng_pkg::MS_DIV_MAGIC;

    always_ff @(posedge i_clk) begin
        r_run_len <= run_full[stng_pkg::MS_DIV_SHIFT +: stng_pkg::RUN_BITS];
        if (cmd_note || cmd_rest) begin
            r_div_num  <= {1'b0, i_freq_hz_q8, stng_pkg::ROUND_BIAS};
            r_div_rem  <= '0;
            r_div_cnt  <= '0;
            r_cmd_rest <= cmd_rest;
            r_run_prod <= stng_pkg::RUN_PROD_BITS'(i_duration_ms)
                          * stng_pkg::RUN_PROD_BITS'(stng_pkg::RATE_HZ);
        end else if (div_active) begin
            r_div_num <= {r_div_num[stng_pkg::DIV_BITS-stng_pkg::DIV_RADIX_BITS-1:0], div_q};
            r_div_rem <= div_rem_nx;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc    <= '0;
            r_phase_step   <= '0;
            r_samples_left <= '0;
            r_is_rest      <= 1'b0;
            r_sample_total <= '0;
        end else if (load_active) begin
            if (!r_cmd_rest) begin
                r_phase_step <= r_div_num[stng_pkg::PHASE_BITS-1:0];
                r_phase_acc  <= '0;
            end
            r_samples_left <= r_run_len;
            r_is_rest      <= r_cmd_rest;
        end else if (tick_fire) begin
            if (!r_is_rest) begin
                r_phase_acc <= r_phase_acc + r_phase_step;
            end
            r_samples_left <= r_samples_left - 1'b1;
            r_sample_total <= r_sample_total + 1'b1;
        end
    end

    // table address: top two phase bits pick the quadrant, odd quadrants mirror
    assign tab_quad = r_phase_acc[stng_pkg::PHASE_BITS-1 -: 2];
    assign tab_k    = r_phase_acc[stng_pkg::PHASE_BITS-3 -: stng_pkg::TABLE_ADDR_BITS];
    assign tab_addr = tab_quad[0] ? (~tab_k + 1'b1) : tab_k;

    stng_ram #(
        .WIDTH (stng_pkg::ROM_BITS),
        .DEPTH (stng_pkg::TABLE_SIZE)
    ) u_qsine_ram (
        .i_clk   (i_clk),
        .i_we    (r_fill_active),
        .i_waddr (r_fill_cnt),
        .i_wdata (stng_pkg::QSINE[r_fill_cnt]),
        .i_re    (tick_fire),
        .i_raddr (tab_addr),
        .o_rdata (ram_q)
    );

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (tick_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (tick_fire) begin
            r_s1_rest  <= r_is_rest;
            r_s1_full  <= tab_quad[0] && (tab_k == '0);
            r_s1_neg   <= tab_quad[1];
            r_s1_last  <= (r_samples_left == stng_pkg::RUN_BITS'(1));
            r_s1_total <= r_sample_total + 1'b1;
        end
    end

    // quarter point past the table end reads full scale
    assign s1_mag    = r_s1_full ? stng_pkg::ROM_BITS'(stng_pkg::FULL_SCALE) : ram_q;
    assign s1_pos    = $signed({1'b0, s1_mag});
    assign s1_sample = r_s1_rest ? '0 : (r_s1_neg ? -s1_pos : s1_pos);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv) begin
            r_out_sample <= s1_sample;
            r_out_last   <= r_s1_last;
            r_out_total  <= r_s1_total;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_sample         = r_out_sample;
    assign o_last_of_note   = r_out_last;
    assign o_samples_so_far = r_out_total;

    `STNG_ASSERT_NOW(a_accept_idle, i_clk, i_rst_n, in_accept, r_state == stng_pkg::ST_IDLE, "word accepted while sequencer busy")
    `STNG_ASSERT_NOW(a_fill_stalls, i_clk, i_rst_n, r_state == stng_pkg::ST_FILL, o_stall, "input open during table fill")
    `STNG_ASSERT_NEXT(a_total_step, i_clk, i_rst_n, tick_fire, r_sample_total == $past(r_sample_total) + 1'b1, "sample count did not advance")
    `STNG_ASSERT_NOW(a_sample_range, i_clk, i_rst_n, o_valid, o_sample != 16'sh8000, "sample out of range")

endmodule
